// ===== design/mtep_pkg.sv =====
// ----------------------------------------------------------------------------
// mtep_pkg
// shared types, codes and helpers of the midi track event parser
// ----------------------------------------------------------------------------
package mtep_pkg;

   localparam int CHANNEL_COUNT = 16;
   localparam int CHANNEL_W     = $clog2(CHANNEL_COUNT);
   localparam int VLQ_CNT_W     = 3;
   localparam logic [VLQ_CNT_W-1:0] MAX_VLQ_BYTES = VLQ_CNT_W'(4);
   localparam int LEN_W         = 28;
   localparam int TICK_W        = 32;
   localparam int TEMPO_W       = 24;

   localparam logic [2:0] KIND_CHANNEL   = 3'd0;
   localparam logic [2:0] KIND_TEMPO     = 3'd1;
   localparam logic [2:0] KIND_END       = 3'd2;
   localparam logic [2:0] KIND_RAN_OUT   = 3'd3;
   localparam logic [2:0] KIND_MALFORMED = 3'd4;

   localparam logic [7:0] STATUS_META   = 8'hFF;
   localparam logic [7:0] STATUS_SYSEX  = 8'hF0;
   localparam logic [7:0] STATUS_ESCAPE = 8'hF7;
   localparam logic [7:0] META_END      = 8'h2F;
   localparam logic [7:0] META_TEMPO    = 8'h51;
   localparam logic [7:0] CTRL_VOLUME   = 8'h07;
   localparam logic [3:0] HI_SYSTEM     = 4'hF;
   localparam logic [3:0] HI_CONTROL    = 4'hB;
   localparam logic [3:0] HI_PROGRAM    = 4'hC;
   localparam logic [3:0] HI_PRESSURE   = 4'hD;

   localparam logic [7:0]  VOLUME_RESET  = 8'd127;
   localparam logic [7:0]  VOLUME_MAX    = 8'd127;
   localparam logic [7:0]  MASTER_RESET  = 8'd255;
   localparam logic [15:0] VOLUME_DIV    = 16'd254;
   localparam logic [15:0] VOLUME_SAT    = 16'(127 * 254);

   typedef struct packed {
      logic [7:0] track_byte;
      logic       chunk_last;
      logic       restart;
   } mtep_req_type;

   typedef struct packed {
      logic [2:0]         event_kind;
      logic [TICK_W-1:0]  event_tick;
      logic [7:0]         status_byte;
      logic [7:0]         first_data;
      logic [7:0]         second_data;
      logic [TEMPO_W-1:0] tempo_value;
   } mtep_rsp_type;

   // min(127, vol * master / 254), divide by 254 as shift by 8 plus one correction
   function automatic logic [7:0] vol_scale(input logic [7:0] vol, input logic [7:0] master);
      logic [15:0] prod;
      logic [7:0]  quot;
      logic [8:0]  rem;
      prod = 16'(vol) * 16'(master);
      quot = prod[15:8];
      rem  = 9'(prod[7:0]) + 9'({quot, 1'b0});
      if (prod >= VOLUME_SAT) begin
         return VOLUME_MAX;
      end
      if (rem >= 9'(VOLUME_DIV)) begin
         return quot + 8'd1;
      end
      return quot;
   endfunction

endpackage

// ===== design/mtep_req_if.sv =====
// ----------------------------------------------------------------------------
// mtep_req_if
// track byte channel of the midi track event parser
// ----------------------------------------------------------------------------
interface mtep_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] track_byte;
   logic       chunk_last;
   logic       restart;

   modport source (output valid, output track_byte, output chunk_last, output restart,
                   input ready);
   modport sink   (input valid, input track_byte, input chunk_last, input restart,
                   output ready);
endinterface

// ===== design/mtep_rsp_if.sv =====
// ----------------------------------------------------------------------------
// mtep_rsp_if
// event channel of the midi track event parser
// ----------------------------------------------------------------------------
interface mtep_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  event_kind;
   logic [31:0] event_tick;
   logic [7:0]  status_byte;
   logic [7:0]  first_data;
   logic [7:0]  second_data;
   logic [23:0] tempo_value;

   modport source (output valid, output event_kind, output event_tick, output status_byte,
                   output first_data, output second_data, output tempo_value,
                   input ready);
   modport sink   (input valid, input event_kind, input event_tick, input status_byte,
                   input first_data, input second_data, input tempo_value,
                   output ready);
endinterface

// ===== design/mtep_csr_if.sv =====
// ----------------------------------------------------------------------------
// mtep_csr_if
// master volume write channel of the midi track event parser
// ----------------------------------------------------------------------------
interface mtep_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] master_volume;

   modport source (output valid, output master_volume, input ready);
   modport sink   (input valid, input master_volume, output ready);
endinterface

// ===== design/midi_track_event_parser.sv =====
// ----------------------------------------------------------------------------
// midi_track_event_parser
// byte-serial track chunk parser emitting channel, tempo and end events
// ----------------------------------------------------------------------------
// Takes one track byte per clock and keeps that rate as long as events are
// taken: each item passes an input register, then the single-pass parser logic
// (delta time accumulation, running status, meta/sysex skipping and the 8x8
// volume multiply) into the event register, which then presents the event of
// that item to the event channel. A held event stalls the input only once the
// input register is full as well. Bytes that finish nothing produce no event.
// Channel volumes live in sixteen flip-flop registers, so there is no clearing
// pass after reset. The master volume may be written at any time the parser is
// idle and is kept over a restart.
module midi_track_event_parser
   import mtep_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   mtep_csr_if.sink       csr_if,
   mtep_req_if.sink       req_if,
   mtep_rsp_if.source     rsp_if
);

   localparam logic [3:0] PH_DELTA     = 4'd0;
   localparam logic [3:0] PH_STATUS    = 4'd1;
   localparam logic [3:0] PH_DATA1     = 4'd2;
   localparam logic [3:0] PH_DATA2     = 4'd3;
   localparam logic [3:0] PH_META_TYPE = 4'd4;
   localparam logic [3:0] PH_META_LEN  = 4'd5;
   localparam logic [3:0] PH_SYSEX_LEN = 4'd6;
   localparam logic [3:0] PH_SKIP      = 4'd7;
   localparam logic [3:0] PH_HALT      = 4'd8;

   logic [7:0]           master_ff;

   logic                 item_valid_ff;
   mtep_req_type         item_ff;

   logic                 res_valid_ff;
   mtep_rsp_type         res_ff;
   mtep_rsp_type         res_in;
   logic                 emit;

   logic [3:0]           phase_ff, phase_in;
   logic [LEN_W-1:0]     acc_ff, acc_in;
   logic [VLQ_CNT_W-1:0] cnt_ff, cnt_in;
   logic [LEN_W-1:0]     remain_ff, remain_in;
   logic [7:0]           run_ff, run_in;
   logic [7:0]           cur_ff, cur_in;
   logic [7:0]           held_ff, held_in;
   logic [7:0]           meta_ff, meta_in;
   logic [TEMPO_W-1:0]   tempo_ff, tempo_in;
   logic [TICK_W-1:0]    tick_ff, tick_in;
   logic [7:0]           vol_ff [CHANNEL_COUNT];

   logic                 vol_we;
   logic [CHANNEL_W-1:0] vol_idx;
   logic [7:0]           vol_data;

   logic                 advance;
   logic                 step;

   // cleared view of the state when restart is set
   logic [3:0]           c_phase;
   logic [LEN_W-1:0]     c_acc;
   logic [VLQ_CNT_W-1:0] c_cnt;
   logic [LEN_W-1:0]     c_remain;
   logic [7:0]           c_run;
   logic [7:0]           c_cur;
   logic [7:0]           c_held;
   logic [7:0]           c_meta;
   logic [TEMPO_W-1:0]   c_tempo;
   logic [TICK_W-1:0]    c_tick;

   logic [7:0]           b;
   logic [LEN_W-1:0]     acc_new;
   logic [VLQ_CNT_W-1:0] cnt_new;
   logic                 vlq_long;
   logic [7:0]           st;
   logic [7:0]           meta_eff;
   logic [TEMPO_W-1:0]   tempo_new;
   logic [LEN_W-1:0]     remain_new;

   logic                 fin;
   logic [7:0]           fin_st;
   logic [7:0]           fin_d1;
   logic [7:0]           fin_d2;
   logic                 fin_is_vol;
   logic [7:0]           fin_scaled;

   assign csr_if.ready = 1'b1;
   assign advance      = !res_valid_ff || rsp_if.ready;
   assign req_if.ready = !item_valid_ff || advance;
   assign step         = item_valid_ff && advance;

   assign rsp_if.valid       = res_valid_ff;
   assign rsp_if.event_kind  = res_ff.event_kind;
   assign rsp_if.event_tick  = res_ff.event_tick;
   assign rsp_if.status_byte = res_ff.status_byte;
   assign rsp_if.first_data  = res_ff.first_data;
   assign rsp_if.second_data = res_ff.second_data;
   assign rsp_if.tempo_value = res_ff.tempo_value;

   always_comb begin
      b = item_ff.track_byte;
      if (item_ff.restart) begin
         c_phase  = PH_DELTA;
         c_acc    = '0;
         c_cnt    = '0;
         c_remain = '0;
         c_run    = '0;
         c_cur    = '0;
         c_held   = '0;
         c_meta   = '0;
         c_tempo  = '0;
         c_tick   = '0;
      end else begin
         c_phase  = phase_ff;
         c_acc    = acc_ff;
         c_cnt    = cnt_ff;
         c_remain = remain_ff;
         c_run    = run_ff;
         c_cur    = cur_ff;
         c_held   = held_ff;
         c_meta   = meta_ff;
         c_tempo  = tempo_ff;
         c_tick   = tick_ff;
      end

      acc_new    = {c_acc[LEN_W-8:0], b[6:0]};
      cnt_new    = c_cnt + VLQ_CNT_W'(1);
      vlq_long   = b[7] && (cnt_new >= MAX_VLQ_BYTES);
      meta_eff   = ((c_meta == META_TEMPO) && (acc_new != LEN_W'(3))) ? 8'h00 : c_meta;
      tempo_new  = (c_meta == META_TEMPO) ? {c_tempo[TEMPO_W-9:0], b} : c_tempo;
      remain_new = c_remain - LEN_W'(1);
      st         = b[7] ? b : c_run;

      phase_in  = c_phase;
      acc_in    = c_acc;
      cnt_in    = c_cnt;
      remain_in = c_remain;
      run_in    = c_run;
      cur_in    = c_cur;
      held_in   = c_held;
      meta_in   = c_meta;
      tempo_in  = c_tempo;
      tick_in   = c_tick;

      emit   = 1'b0;
      res_in = '0;
      fin    = 1'b0;
      fin_st = c_cur;
      fin_d1 = b;
      fin_d2 = 8'h00;

      unique case (c_phase)
         PH_DELTA: begin
            acc_in = acc_new;
            cnt_in = cnt_new;
            if (!b[7]) begin
               tick_in  = c_tick + TICK_W'(acc_new);
               phase_in = PH_STATUS;
            end else if (vlq_long) begin
               phase_in          = PH_HALT;
               emit              = 1'b1;
               res_in.event_kind = KIND_MALFORMED;
            end
         end
         PH_STATUS: begin
            if (b[7]) begin
               run_in = (b[7:4] != HI_SYSTEM) ? b : 8'h00;
            end
            if (!b[7] && (c_run == 8'h00)) begin
               phase_in          = PH_HALT;
               emit              = 1'b1;
               res_in.event_kind = KIND_MALFORMED;
            end else if (st == STATUS_META) begin
               phase_in = PH_META_TYPE;
            end else if ((st == STATUS_SYSEX) || (st == STATUS_ESCAPE)) begin
               meta_in  = 8'h00;
               acc_in   = '0;
               cnt_in   = '0;
               phase_in = PH_SYSEX_LEN;
            end else if (st[7:4] == HI_SYSTEM) begin
               phase_in          = PH_HALT;
               emit              = 1'b1;
               res_in.event_kind = KIND_MALFORMED;
            end else begin
               cur_in = st;
               fin_st = st;
               if (b[7]) begin
                  phase_in = PH_DATA1;
               end else if ((st[7:4] == HI_PROGRAM) || (st[7:4] == HI_PRESSURE)) begin
                  fin = 1'b1;
               end else begin
                  held_in  = b;
                  phase_in = PH_DATA2;
               end
            end
         end
         PH_DATA1: begin
            if ((c_cur[7:4] == HI_PROGRAM) || (c_cur[7:4] == HI_PRESSURE)) begin
               fin = 1'b1;
            end else begin
               held_in  = b;
               phase_in = PH_DATA2;
            end
         end
         PH_DATA2: begin
            fin    = 1'b1;
            fin_d1 = c_held;
            fin_d2 = b;
         end
         PH_META_TYPE: begin
            meta_in  = b;
            acc_in   = '0;
            cnt_in   = '0;
            phase_in = PH_META_LEN;
         end
         PH_META_LEN, PH_SYSEX_LEN: begin
            acc_in = acc_new;
            cnt_in = cnt_new;
            if (!b[7]) begin
               meta_in = meta_eff;
               if (acc_new == '0) begin
                  if (meta_eff == META_END) begin
                     phase_in          = PH_HALT;
                     emit              = 1'b1;
                     res_in.event_kind = KIND_END;
                  end else begin
                     acc_in   = '0;
                     cnt_in   = '0;
                     phase_in = PH_DELTA;
                  end
               end else begin
                  remain_in = acc_new;
                  tempo_in  = '0;
                  phase_in  = PH_SKIP;
               end
            end else if (vlq_long) begin
               phase_in          = PH_HALT;
               emit              = 1'b1;
               res_in.event_kind = KIND_MALFORMED;
            end
         end
         PH_SKIP: begin
            tempo_in  = tempo_new;
            remain_in = remain_new;
            if (remain_new == '0) begin
               if (c_meta == META_END) begin
                  phase_in          = PH_HALT;
                  emit              = 1'b1;
                  res_in.event_kind = KIND_END;
               end else begin
                  acc_in   = '0;
                  cnt_in   = '0;
                  phase_in = PH_DELTA;
                  if ((c_meta == META_TEMPO) && (tempo_new != '0)) begin
                     emit               = 1'b1;
                     res_in.event_kind  = KIND_TEMPO;
                     res_in.tempo_value = tempo_new;
                  end
               end
            end
         end
         default: begin
            phase_in = PH_HALT;
         end
      endcase

      fin_is_vol = (fin_st[7:4] == HI_CONTROL) && (fin_d1 == CTRL_VOLUME);
      fin_scaled = vol_scale(fin_d2, master_ff);

      if (fin) begin
         acc_in             = '0;
         cnt_in             = '0;
         phase_in           = PH_DELTA;
         emit               = 1'b1;
         res_in.event_kind  = KIND_CHANNEL;
         res_in.status_byte = fin_st;
         res_in.first_data  = fin_d1;
         res_in.second_data = fin_is_vol ? fin_scaled : fin_d2;
      end

      if (item_ff.chunk_last && (phase_in != PH_HALT)) begin
         phase_in = PH_HALT;
         if (!emit) begin
            emit              = 1'b1;
            res_in.event_kind = KIND_RAN_OUT;
         end
      end

      res_in.event_tick = tick_in;

      vol_we   = fin && fin_is_vol;
      vol_idx  = fin_st[CHANNEL_W-1:0];
      vol_data = fin_d2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         master_ff <= MASTER_RESET;
      end else if (csr_if.valid && csr_if.ready) begin
         master_ff <= csr_if.master_volume;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_if.valid && req_if.ready) begin
         item_valid_ff <= 1'b1;
      end else if (step) begin
         item_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         item_ff.track_byte <= req_if.track_byte;
         item_ff.chunk_last <= req_if.chunk_last;
         item_ff.restart    <= req_if.restart;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_valid_ff <= 1'b0;
      end else if (advance) begin
         res_valid_ff <= step && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (step && emit) begin
         res_ff <= res_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_DELTA;
         acc_ff    <= '0;
         cnt_ff    <= '0;
         remain_ff <= '0;
         run_ff    <= '0;
         cur_ff    <= '0;
         held_ff   <= '0;
         meta_ff   <= '0;
         tempo_ff  <= '0;
         tick_ff   <= '0;
         for (int i = 0; i < CHANNEL_COUNT; i++) begin
            vol_ff[i] <= VOLUME_RESET;
         end
      end else if (step) begin
         phase_ff  <= phase_in;
         acc_ff    <= acc_in;
         cnt_ff    <= cnt_in;
         remain_ff <= remain_in;
         run_ff    <= run_in;
         cur_ff    <= cur_in;
         held_ff   <= held_in;
         meta_ff   <= meta_in;
         tempo_ff  <= tempo_in;
         tick_ff   <= tick_in;
         for (int i = 0; i < CHANNEL_COUNT; i++) begin
            if (vol_we && (vol_idx == CHANNEL_W'(i))) begin
               vol_ff[i] <= vol_data;
            end else if (item_ff.restart) begin
               vol_ff[i] <= VOLUME_RESET;
            end
         end
      end
   end

`ifndef SYNTH
   a_vol_event_matches_store: assert property (@(posedge clock) disable iff (reset)
      res_valid_ff && (res_ff.event_kind == KIND_CHANNEL)
      && (res_ff.status_byte[7:4] == HI_CONTROL) && (res_ff.first_data == CTRL_VOLUME)
      |-> res_ff.second_data
          == vol_scale(vol_ff[res_ff.status_byte[CHANNEL_W-1:0]], master_ff))
      else $error("volume event does not match stored channel volume");

   a_stop_event_halts: assert property (@(posedge clock) disable iff (reset)
      res_valid_ff && ((res_ff.event_kind == KIND_END) || (res_ff.event_kind == KIND_RAN_OUT)
      || (res_ff.event_kind == KIND_MALFORMED))
      |-> phase_ff == PH_HALT)
      else $error("stop event without halted parser");

   a_halt_is_silent: assert property (@(posedge clock) disable iff (reset)
      step && (phase_ff == PH_HALT) && !item_ff.restart
      |=> !res_valid_ff && (phase_ff == PH_HALT))
      else $error("halted parser produced an event or resumed");
`endif

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking testbench of the midi track event parser
// ----------------------------------------------------------------------------
// Streams track chunks into the parser one byte per item: a few directed
// chunks first, then random tracks built from delta times, channel messages
// with and without running status, tempo and other meta events and sysex
// blocks, mixed with truncated, broken and noise chunks. Each phase runs
// under a newly written master volume. A behavioral parser predicts any event
// of every accepted byte and the monitor compares each event field by field.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import mtep_pkg::*;

   localparam logic [3:0] HI_NOTE_ON  = 4'h9;
   localparam int         ERR_PRINTS  = 40;
   localparam int         PHASE_BYTES = 125;

   typedef enum logic [3:0] {
      WAIT_DELTA, WAIT_STATUS, WAIT_DATA1, WAIT_DATA2, WAIT_META_TYPE,
      WAIT_META_LEN, WAIT_SYSEX_LEN, SKIP_BODY, STOPPED
   } parser_state_type;

   typedef enum logic [1:0] {VLQ_MORE, VLQ_DONE, VLQ_LONG} vlq_step_type;

   logic clock = 1'b0;
   logic reset;

   mtep_req_if req();
   mtep_rsp_if rsp();
   mtep_csr_if csr();

   midi_track_event_parser DUT (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr),
      .req_if (req),
      .rsp_if (rsp)
   );

   // shadow parser state
   parser_state_type   trk_state;
   logic [LEN_W-1:0]   trk_acc;
   logic [VLQ_CNT_W-1:0] trk_vlq_cnt;
   logic [LEN_W-1:0]   trk_left;
   logic [7:0]         trk_running;
   logic [7:0]         trk_status;
   logic [7:0]         trk_held;
   logic [7:0]         trk_meta;
   logic [TEMPO_W-1:0] trk_tempo;
   logic [TICK_W-1:0]  trk_tick;
   logic [7:0]         chan_vol [CHANNEL_COUNT];
   logic [7:0]         master_vol;

   mtep_req_type pending_bytes [$];
   mtep_rsp_type pending_events [$];
   logic [7:0]   chunk [$];
   logic [7:0]   gen_running;
   int unsigned  phase_bytes;
   bit           calm;
   int unsigned  error_count;
   int unsigned  bytes_taken;
   int unsigned  master_writes;
   int unsigned  kind_seen [5];

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic report_error(string msg);
      if (error_count < ERR_PRINTS) begin
         $display("ERROR at %0t ns: %s", $time, msg);
      end
      error_count++;
   endtask

   function automatic void clear_track();
      trk_state   = WAIT_DELTA;
      trk_acc     = '0;
      trk_vlq_cnt = '0;
      trk_left    = '0;
      trk_running = '0;
      trk_status  = '0;
      trk_held    = '0;
      trk_meta    = '0;
      trk_tempo   = '0;
      trk_tick    = '0;
      foreach (chan_vol[i]) chan_vol[i] = VOLUME_RESET;
   endfunction

   function automatic void begin_vlq(parser_state_type next);
      trk_acc     = '0;
      trk_vlq_cnt = '0;
      trk_state   = next;
   endfunction

   function automatic mtep_rsp_type make_event(logic [2:0] kind, logic [7:0] st,
                                               logic [7:0] d1, logic [7:0] d2,
                                               logic [TEMPO_W-1:0] tempo);
      mtep_rsp_type ev;
      ev.event_kind  = kind;
      ev.event_tick  = trk_tick;
      ev.status_byte = st;
      ev.first_data  = d1;
      ev.second_data = d2;
      ev.tempo_value = tempo;
      return ev;
   endfunction

   function automatic vlq_step_type vlq_take(logic [7:0] b);
      trk_acc     = {trk_acc[LEN_W-8:0], b[6:0]};
      trk_vlq_cnt = trk_vlq_cnt + VLQ_CNT_W'(1);
      if (!b[7]) return VLQ_DONE;
      if (trk_vlq_cnt >= MAX_VLQ_BYTES) return VLQ_LONG;
      return VLQ_MORE;
   endfunction

   function automatic bit flag_bad(output mtep_rsp_type ev);
      trk_state = STOPPED;
      ev = make_event(KIND_MALFORMED, '0, '0, '0, '0);
      return 1'b1;
   endfunction

   function automatic bit close_message(logic [7:0] d1, logic [7:0] d2,
                                        output mtep_rsp_type ev);
      int scaled;
      if (trk_status[7:4] == HI_CONTROL && d1 == CTRL_VOLUME) begin
         chan_vol[trk_status[3:0]] = d2;
         scaled = int'(d2) * int'(master_vol) / int'(VOLUME_DIV);
         d2 = (scaled > int'(VOLUME_MAX)) ? VOLUME_MAX : 8'(scaled);
      end
      begin_vlq(WAIT_DELTA);
      ev = make_event(KIND_CHANNEL, trk_status, d1, d2, '0);
      return 1'b1;
   endfunction

   function automatic bit take_first(logic [7:0] b, output mtep_rsp_type ev);
      if (trk_status[7:4] == HI_PROGRAM || trk_status[7:4] == HI_PRESSURE) begin
         return close_message(b, 8'h00, ev);
      end
      trk_held  = b;
      trk_state = WAIT_DATA2;
      return 1'b0;
   endfunction

   // event caused by one track byte, if any
   function automatic bit parse_byte(mtep_req_type it, output mtep_rsp_type ev);
      logic [7:0]   b;
      logic [7:0]   st;
      bit           got;
      bit           data_now;
      vlq_step_type r;
      b   = it.track_byte;
      got = 1'b0;
      ev  = '0;
      if (it.restart) clear_track();
      if (trk_state == STOPPED) return 1'b0;
      case (trk_state)
         WAIT_DELTA: begin
            r = vlq_take(b);
            if (r == VLQ_LONG) begin
               got = flag_bad(ev);
            end else if (r == VLQ_DONE) begin
               trk_tick += TICK_W'(trk_acc);
               trk_state = WAIT_STATUS;
            end
         end
         WAIT_STATUS: begin
            data_now = !b[7];
            st = data_now ? trk_running : b;
            if (!data_now) trk_running = (b[7:4] != HI_SYSTEM) ? b : 8'h00;
            if (data_now && trk_running == 8'h00) begin
               got = flag_bad(ev);
            end else if (st == STATUS_META) begin
               trk_state = WAIT_META_TYPE;
            end else if (st == STATUS_SYSEX || st == STATUS_ESCAPE) begin
               trk_meta = '0;
               begin_vlq(WAIT_SYSEX_LEN);
            end else if (st[7:4] == HI_SYSTEM) begin
               got = flag_bad(ev);
            end else begin
               trk_status = st;
               if (data_now) got = take_first(b, ev);
               else trk_state = WAIT_DATA1;
            end
         end
         WAIT_DATA1: got = take_first(b, ev);
         WAIT_DATA2: got = close_message(trk_held, b, ev);
         WAIT_META_TYPE: begin
            trk_meta = b;
            begin_vlq(WAIT_META_LEN);
         end
         WAIT_META_LEN, WAIT_SYSEX_LEN: begin
            r = vlq_take(b);
            if (r == VLQ_LONG) begin
               got = flag_bad(ev);
            end else if (r == VLQ_DONE) begin
               if (trk_meta == META_TEMPO && trk_acc != LEN_W'(3)) trk_meta = '0;
               if (trk_acc != '0) begin
                  trk_left  = trk_acc;
                  trk_tempo = '0;
                  trk_state = SKIP_BODY;
               end else if (trk_meta == META_END) begin
                  trk_state = STOPPED;
                  ev  = make_event(KIND_END, '0, '0, '0, '0);
                  got = 1'b1;
               end else begin
                  begin_vlq(WAIT_DELTA);
               end
            end
         end
         SKIP_BODY: begin
            if (trk_meta == META_TEMPO) trk_tempo = {trk_tempo[15:0], b};
            trk_left = trk_left - LEN_W'(1);
            if (trk_left == '0) begin
               if (trk_meta == META_END) begin
                  trk_state = STOPPED;
                  ev  = make_event(KIND_END, '0, '0, '0, '0);
                  got = 1'b1;
               end else begin
                  begin_vlq(WAIT_DELTA);
                  if (trk_meta == META_TEMPO && trk_tempo != '0) begin
                     ev  = make_event(KIND_TEMPO, '0, '0, '0, trk_tempo);
                     got = 1'b1;
                  end
               end
            end
         end
         default: trk_state = STOPPED;
      endcase
      if (it.chunk_last && trk_state != STOPPED) begin
         trk_state = STOPPED;
         if (!got) begin
            ev  = make_event(KIND_RAN_OUT, '0, '0, '0, '0);
            got = 1'b1;
         end
      end
      return got;
   endfunction

   // driver
   always @(posedge clock) begin : drive
      mtep_req_type on_bus;
      mtep_rsp_type ev;
      if (reset) begin
         req.valid <= 1'b0;
      end else begin
         if (req.valid && req.ready) begin
            bytes_taken++;
            if (parse_byte(on_bus, ev)) pending_events.push_back(ev);
         end
         if (!req.valid || req.ready) begin
            if (pending_bytes.size() != 0 && (calm || $urandom_range(99) >= 23)) begin
               on_bus = pending_bytes.pop_front();
               req.valid      <= 1'b1;
               req.track_byte <= on_bus.track_byte;
               req.chunk_last <= on_bus.chunk_last;
               req.restart    <= on_bus.restart;
            end else begin
               req.valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) begin
         report_error($sformatf("%s got %0h expected %0h", name, got, want));
      end
   endtask

   // monitor
   always @(posedge clock) begin : watch
      mtep_rsp_type want;
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (rsp.event_kind <= KIND_MALFORMED) kind_seen[rsp.event_kind]++;
            if (pending_events.size() == 0) begin
               report_error($sformatf("unexpected event kind %0d tick %0h",
                                      rsp.event_kind, rsp.event_tick));
            end else begin
               want = pending_events.pop_front();
               check_field("event_kind", 32'(rsp.event_kind), 32'(want.event_kind));
               check_field("event_tick", rsp.event_tick, want.event_tick);
               check_field("status_byte", 32'(rsp.status_byte), 32'(want.status_byte));
               check_field("first_data", 32'(rsp.first_data), 32'(want.first_data));
               check_field("second_data", 32'(rsp.second_data), 32'(want.second_data));
               check_field("tempo_value", 32'(rsp.tempo_value), 32'(want.tempo_value));
            end
         end
         rsp.ready <= calm || ($urandom_range(99) >= 23);
      end
   end

   function automatic logic [7:0] data_byte();
      return ($urandom_range(99) < 85) ? 8'($urandom_range(127)) : 8'($urandom);
   endfunction

   task automatic add_vlq(int unsigned value, int unsigned pad);
      int unsigned n;
      int unsigned i;
      n = 1;
      while (n < 4 && (value >> (7 * n)) != 0) n++;
      n = (n + pad > 4) ? 4 : n + pad;
      for (i = n; i > 0; i--) begin
         chunk.push_back(8'((value >> (7 * (i - 1))) & 32'h7F) | ((i > 1) ? 8'h80 : 8'h00));
      end
   endtask

   task automatic add_delta();
      int unsigned roll;
      int unsigned pad;
      roll = $urandom_range(99);
      pad  = ($urandom_range(99) < 10) ? $urandom_range(3, 1) : 0;
      if (roll < 2) begin
         repeat (4) chunk.push_back(8'h80 | 8'($urandom));
      end else if (roll < 55) begin
         add_vlq(0, pad);
      end else if (roll < 80) begin
         add_vlq($urandom_range(127, 1), pad);
      end else if (roll < 95) begin
         add_vlq($urandom_range(16383, 128), pad);
      end else begin
         add_vlq($urandom_range(32'h0FFFFFFF, 16384), pad);
      end
   endtask

   task automatic add_track_event(output bit broken);
      int unsigned roll;
      int unsigned len;
      logic [7:0]  st;
      logic [23:0] tempo;
      roll   = $urandom_range(99);
      broken = 1'b0;
      if (roll < 56) begin
         if (gen_running != 8'h00 && $urandom_range(99) < 40) begin
            st = gen_running;
         end else begin
            st = {4'($urandom_range(14, 8)), 4'($urandom)};
            chunk.push_back(st);
            gen_running = st;
         end
         if (st[7:4] == HI_CONTROL && $urandom_range(99) < 40) chunk.push_back(CTRL_VOLUME);
         else chunk.push_back(data_byte());
         if (st[7:4] != HI_PROGRAM && st[7:4] != HI_PRESSURE) chunk.push_back(data_byte());
      end else if (roll < 68) begin
         chunk.push_back(STATUS_META);
         chunk.push_back(META_TEMPO);
         len = $urandom_range(5, 0);
         if ($urandom_range(99) < 75 || len == 3) len = 3;
         add_vlq(len, ($urandom_range(99) < 10) ? 1 : 0);
         tempo = ($urandom_range(99) < 10) ? 24'h0 : 24'($urandom);
         if (len == 3) begin
            chunk.push_back(tempo[23:16]);
            chunk.push_back(tempo[15:8]);
            chunk.push_back(tempo[7:0]);
         end else begin
            repeat (len) chunk.push_back(8'($urandom));
         end
         gen_running = 8'h00;
      end else if (roll < 80) begin
         chunk.push_back(STATUS_META);
         st = 8'($urandom);
         chunk.push_back((st == META_END) ? 8'h01 : st);
         len = $urandom_range(5, 0);
         add_vlq(len, ($urandom_range(99) < 10) ? 1 : 0);
         repeat (len) chunk.push_back(8'($urandom));
         gen_running = 8'h00;
      end else if (roll < 92) begin
         chunk.push_back($urandom_range(1) ? STATUS_SYSEX : STATUS_ESCAPE);
         len = $urandom_range(6, 0);
         add_vlq(len, 0);
         repeat (len) chunk.push_back(8'($urandom));
         gen_running = 8'h00;
      end else begin
         broken = 1'b1;
         roll = $urandom_range(2);
         if (roll == 0 && gen_running == 8'h00) begin
            chunk.push_back(8'($urandom_range(127)));
         end else if (roll == 2) begin
            chunk.push_back(STATUS_META);
            chunk.push_back(8'($urandom));
            repeat (4) chunk.push_back(8'h80 | 8'($urandom));
         end else begin
            do st = {HI_SYSTEM, 4'($urandom)};
            while (st == STATUS_SYSEX || st == STATUS_ESCAPE || st == STATUS_META);
            chunk.push_back(st);
         end
      end
   endtask

   task automatic send_chunk(int unsigned keep, int unsigned mid);
      mtep_req_type item;
      int unsigned  i;
      for (i = 0; i < keep; i++) begin
         item.track_byte = chunk[i];
         item.restart    = (i == 0) || (i == mid);
         item.chunk_last = (i == keep - 1);
         pending_bytes.push_back(item);
      end
      phase_bytes += keep;
      chunk.delete();
   endtask

   task automatic add_random_chunk();
      int unsigned roll;
      int unsigned n_events;
      int unsigned keep;
      int unsigned mid;
      int unsigned k;
      bit          broken;
      chunk.delete();
      gen_running = 8'h00;
      broken = 1'b0;
      roll = $urandom_range(99);
      if (roll < 8) begin
         repeat ($urandom_range(8, 2)) chunk.push_back(8'($urandom));
      end else begin
         n_events = $urandom_range(6, 1);
         for (k = 0; k < n_events && !broken; k++) begin
            add_delta();
            add_track_event(broken);
         end
         if (!broken && $urandom_range(99) < 75) begin
            add_delta();
            chunk.push_back(STATUS_META);
            chunk.push_back(META_END);
            if ($urandom_range(99) < 20) begin
               k = $urandom_range(2, 1);
               add_vlq(k, 0);
               repeat (k) chunk.push_back(8'($urandom));
            end else begin
               chunk.push_back(8'h00);
            end
         end
      end
      keep = chunk.size();
      if ($urandom_range(99) < 15) keep = $urandom_range(chunk.size(), 1);
      mid = (keep > 1 && $urandom_range(99) < 8) ? $urandom_range(keep - 1, 1) : 0;
      send_chunk(keep, mid);
   endtask

   task automatic set_master(logic [7:0] value);
      @(posedge clock);
      csr.valid         <= 1'b1;
      csr.master_volume <= value;
      do @(posedge clock);
      while (!csr.ready);
      master_vol = value;
      master_writes++;
      csr.valid <= 1'b0;
   endtask

   task automatic settle();
      while (pending_bytes.size() != 0 || req.valid || pending_events.size() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
   endtask

   initial begin : stimulus
      logic [7:0]  masters [6];
      int unsigned p;
      masters = '{8'd0, 8'd255, 8'd1, 8'd254, 8'($urandom_range(253, 2)), 8'd128};
      reset = 1'b1;
      calm  = 1'b0;
      req.valid = 1'b0;
      req.track_byte = '0;
      req.chunk_last = 1'b0;
      req.restart = 1'b0;
      rsp.ready = 1'b0;
      csr.valid = 1'b0;
      csr.master_volume = '0;
      master_vol = MASTER_RESET;
      clear_track();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // full track: notes, running status, max delta, one-byte message with
      // high data bit, saturated volume, tempo, end of track
      add_vlq(0, 0);
      chunk.push_back({HI_NOTE_ON, 4'h0});
      chunk.push_back(8'h3C);
      chunk.push_back(8'h7F);
      add_vlq(0, 0);
      chunk.push_back(8'h3C);
      chunk.push_back(8'h00);
      add_vlq(32'h0FFFFFFF, 0);
      chunk.push_back({HI_PRESSURE, 4'h3});
      chunk.push_back(8'h80);
      add_vlq(0, 0);
      chunk.push_back({HI_CONTROL, 4'hF});
      chunk.push_back(CTRL_VOLUME);
      chunk.push_back(8'hFF);
      add_vlq(0, 0);
      chunk.push_back(STATUS_META);
      chunk.push_back(META_TEMPO);
      add_vlq(3, 0);
      chunk.push_back(8'h07);
      chunk.push_back(8'hA1);
      chunk.push_back(8'h20);
      add_vlq(0, 0);
      chunk.push_back(STATUS_META);
      chunk.push_back(META_END);
      chunk.push_back(8'h00);
      send_chunk(chunk.size(), 0);
      // delta too long
      repeat (4) chunk.push_back(8'hFF);
      send_chunk(chunk.size(), 0);
      // data byte with no running status
      add_vlq(0, 0);
      chunk.push_back(8'h40);
      send_chunk(chunk.size(), 0);
      // bad system status
      add_vlq(0, 0);
      chunk.push_back({HI_SYSTEM, 4'h1});
      send_chunk(chunk.size(), 0);
      // chunk cut inside a message
      add_vlq(0, 0);
      chunk.push_back({HI_NOTE_ON, 4'h1});
      send_chunk(chunk.size(), 0);
      settle();

      for (p = 0; p < 6; p++) begin
         set_master(masters[p]);
         calm = (p == 2);
         phase_bytes = 0;
         if (p == 3) begin
            // tick wraps past 2^32
            add_vlq(0, 0);
            chunk.push_back({HI_NOTE_ON, 4'h5});
            chunk.push_back(8'h3C);
            chunk.push_back(8'h40);
            repeat (18) begin
               add_vlq(32'h0FFFFFFF, 0);
               chunk.push_back(8'h3C);
               chunk.push_back(8'h40);
            end
            add_vlq(0, 0);
            chunk.push_back(STATUS_META);
            chunk.push_back(META_END);
            chunk.push_back(8'h00);
            send_chunk(chunk.size(), 0);
         end
         while (phase_bytes < PHASE_BYTES) add_random_chunk();
         settle();
      end
      calm = 1'b0;

      $display("%0d track bytes taken under %0d master volume settings",
               bytes_taken, master_writes + 1);
      $display("events seen: %0d channel, %0d tempo, %0d end, %0d ran out, %0d malformed",
               kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4]);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches", error_count);
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin : watchdog
      #5ms;
      $display("run timed out");
      $display("== FAIL ==");
      $finish;
   end

endmodule
